// ----- src/pxd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pxd_pkg
// Shared types and constants of the pixel XOR frame decoder.
// ----------------------------------------------------------------------------
package pxd_pkg;

  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned Q_CW    = $clog2(Q_DEPTH + 1);

  localparam logic [7:0] MARKER_BYTE = 8'hCC;
  localparam logic [7:0] VERSION_ONE = 8'h01;
  localparam logic [7:0] SALT_FIRST  = 8'h9E;
  localparam logic [7:0] SALT_SECOND = 8'h37;
  localparam logic [7:0] SALT_THIRD  = 8'h79;

  localparam logic [1:0] REG_KEY_LOW     = 2'd0;
  localparam logic [1:0] REG_KEY_MID     = 2'd1;
  localparam logic [1:0] REG_PIXEL_COUNT = 2'd2;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_SHORT_IMAGE  = 3'd1,
    ST_BAD_MARKER   = 3'd2,
    ST_BAD_VERSION  = 3'd3,
    ST_BAD_CHECKSUM = 3'd4,
    ST_TOO_LONG     = 3'd5
  } status_e;

  // One request from the front end to the output side.
  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [1:0]  valid_count;
    status_e     status;
    logic [31:0] payload_length;
    logic        last;
    logic [31:0] block_index;
  } cmd_t;

endpackage
`default_nettype wire

// ----- src/pxd_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pxd_front
// Frame tracking: header capture and checks, payload byte accounting.
// Emits one request per pixel that produces a result.
// ----------------------------------------------------------------------------
module pxd_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          accept_i,
  input  wire logic          frame_start_i,
  input  wire logic [7:0]    red_i,
  input  wire logic [7:0]    green_i,
  input  wire logic [7:0]    blue_i,
  input  wire logic [30:0]   pixel_count_i,
  output pxd_pkg::cmd_t      cmd_o,
  output logic               push_o
);
  import pxd_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HEADER,
    PH_PAYLOAD,
    PH_DONE
  } phase_e;

  phase_e      phase_q, phase_d, phase_eff;
  logic [1:0]  hdr_idx_q, hdr_idx_d, hdr_idx_eff;
  logic [47:0] hdr_q, hdr_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] blk_q, blk_d;

  logic [31:0] hdr_len;
  logic [7:0]  hdr_sum;
  logic        short_image;
  logic [30:0] room;
  logic [32:0] room_x3;
  logic        too_long;
  logic [1:0]  take;
  logic [31:0] rem_next;

  assign hdr_len = {hdr_q[15:8], hdr_q[23:16], hdr_q[31:24], hdr_q[39:32]};
  assign hdr_sum = hdr_q[7:0] ^ hdr_q[15:8] ^ hdr_q[23:16] ^ hdr_q[31:24]
                 ^ hdr_q[39:32] ^ hdr_q[47:40] ^ red_i;

  assign short_image = (pixel_count_i <= 31'd4);

  // 4 + ceil(len/3) > count  <=>  len > 3 * (count - 4), for count >= 4
  assign room     = pixel_count_i - 31'd4;
  assign room_x3  = {1'b0, room, 1'b0} + {2'b00, room};
  assign too_long = (pixel_count_i < 31'd4) || ({1'b0, hdr_len} > room_x3);

  assign take     = (rem_q < 32'd3) ? rem_q[1:0] : 2'd3;
  assign rem_next = rem_q - {30'd0, take};

  assign phase_eff   = frame_start_i ? PH_HEADER : phase_q;
  assign hdr_idx_eff = frame_start_i ? 2'd0 : hdr_idx_q;

  always_comb begin
    phase_d   = phase_q;
    hdr_idx_d = hdr_idx_q;
    hdr_d     = hdr_q;
    rem_d     = rem_q;
    blk_d     = blk_q;
    push_o    = 1'b0;
    cmd_o     = '0;
    cmd_o.red   = red_i;
    cmd_o.green = green_i;
    cmd_o.blue  = blue_i;
    cmd_o.block_index = blk_q;
    if (accept_i) begin
      if (frame_start_i) begin
        hdr_idx_d = 2'd0;
        hdr_d     = '0;
        rem_d     = '0;
        blk_d     = '0;
      end
      if (frame_start_i && short_image) begin
        phase_d      = PH_DONE;
        push_o       = 1'b1;
        cmd_o.status = ST_SHORT_IMAGE;
        cmd_o.last   = 1'b1;
      end else begin
        case (phase_eff)
          PH_HEADER: begin
            case (hdr_idx_eff)
              2'd0: begin
                phase_d   = PH_HEADER;
                hdr_d     = {24'd0, blue_i, green_i, red_i};
                hdr_idx_d = 2'd1;
              end
              2'd1: begin
                hdr_d[47:24] = {blue_i, green_i, red_i};
                hdr_idx_d    = 2'd2;
              end
              2'd2: begin
                cmd_o.payload_length = hdr_len;
                cmd_o.last           = 1'b1;
                if (blue_i != MARKER_BYTE) begin
                  cmd_o.status = ST_BAD_MARKER;
                end else if (hdr_q[7:0] != VERSION_ONE) begin
                  cmd_o.status = ST_BAD_VERSION;
                end else if (green_i != hdr_sum) begin
                  cmd_o.status = ST_BAD_CHECKSUM;
                end else if (too_long) begin
                  cmd_o.status = ST_TOO_LONG;
                end else begin
                  cmd_o.status = ST_OK;
                end
                if (cmd_o.status != ST_OK) begin
                  phase_d = PH_DONE;
                  push_o  = 1'b1;
                end else begin
                  rem_d     = hdr_len;
                  hdr_idx_d = 2'd3;
                  if (hdr_len == 32'd0) begin
                    phase_d = PH_DONE;
                    push_o  = 1'b1;
                    cmd_o.payload_length = '0;
                  end
                end
              end
              default: begin
                phase_d = PH_PAYLOAD;
              end
            endcase
          end
          PH_PAYLOAD: begin
            push_o               = 1'b1;
            cmd_o.valid_count    = take;
            cmd_o.status         = ST_OK;
            cmd_o.payload_length = hdr_len;
            cmd_o.last           = (rem_next == 32'd0);
            rem_d                = rem_next;
            blk_d                = blk_q + 32'd1;
            if (rem_next == 32'd0) begin
              phase_d = PH_DONE;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      hdr_idx_q <= '0;
      hdr_q     <= '0;
      rem_q     <= '0;
      blk_q     <= '0;
    end else begin
      phase_q   <= phase_d;
      hdr_idx_q <= hdr_idx_d;
      hdr_q     <= hdr_d;
      rem_q     <= rem_d;
      blk_q     <= blk_d;
    end
  end

  // Without a frame start, results only come from an open frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && !frame_start_i) |-> (phase_q == PH_HEADER || phase_q == PH_PAYLOAD))
    else $error("request issued outside an open frame");

  // Every error closes the frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && cmd_o.status != ST_OK) |=> (phase_q == PH_DONE))
    else $error("error did not end the frame");

  // A payload result never claims more bytes than were left.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && phase_q == PH_PAYLOAD && !frame_start_i)
      |-> ({30'd0, cmd_o.valid_count} <= rem_q && cmd_o.valid_count != 2'd0))
    else $error("payload byte count out of range");

endmodule
`default_nettype wire

// ----- src/pxd_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pxd_queue
// Short request queue between the frame tracker and the output stage.
// ----------------------------------------------------------------------------
module pxd_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  pxd_pkg::cmd_t      push_data_i,
  output logic               ready_o,
  input  wire logic          pop_i,
  output logic               valid_o,
  output pxd_pkg::cmd_t      pop_data_o
);
  import pxd_pkg::*;

  cmd_t              mem_q [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [Q_AW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [Q_CW-1:0]   count_q, count_d;
  logic              do_push, do_pop;

  assign ready_o    = (count_q != Q_CW'(Q_DEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && ready_o;
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> ready_o)
    else $error("request pushed into a full queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= Q_CW'(Q_DEPTH))
    else $error("queue count beyond depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue count lost a push");

endmodule
`default_nettype wire

// ----- src/pxd_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pxd_back
// Output stage: subkey generation, XOR of the payload bytes, result register.
// ----------------------------------------------------------------------------
module pxd_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic [23:0]   key_low_i,
  input  wire logic [23:0]   key_mid_i,
  input  wire logic          cmd_valid_i,
  input  pxd_pkg::cmd_t      cmd_i,
  output logic               cmd_pop_o,
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  output logic [63:0]        m_axis_tdata,
  output logic [2:0]         m_axis_tuser,
  output logic               m_axis_tlast
);
  import pxd_pkg::*;

  logic        out_valid_q;
  logic [7:0]  b0_q, b1_q, b2_q;
  logic [1:0]  cnt_q;
  status_e     status_q;
  logic [31:0] len_q;
  logic        last_q;

  logic [7:0]  fold;
  logic [7:0]  k0, k1, k2;
  logic [7:0]  b0_d, b1_d, b2_d;

  assign fold = cmd_i.block_index[7:0] ^ cmd_i.block_index[15:8]
              ^ cmd_i.block_index[23:16] ^ cmd_i.block_index[31:24];
  assign k0 = key_low_i[7:0]   ^ key_mid_i[7:0]   ^ fold ^ SALT_FIRST;
  assign k1 = key_low_i[15:8]  ^ key_mid_i[15:8]  ^ fold ^ SALT_SECOND;
  assign k2 = key_low_i[23:16] ^ key_mid_i[23:16] ^ fold ^ SALT_THIRD;

  assign b0_d = (cmd_i.valid_count >= 2'd1) ? (cmd_i.red   ^ k0) : 8'd0;
  assign b1_d = (cmd_i.valid_count >= 2'd2) ? (cmd_i.green ^ k1) : 8'd0;
  assign b2_d = (cmd_i.valid_count == 2'd3) ? (cmd_i.blue  ^ k2) : 8'd0;

  assign cmd_pop_o = cmd_valid_i && (!out_valid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_pop_o) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      b0_q     <= b0_d;
      b1_q     <= b1_d;
      b2_q     <= b2_d;
      cnt_q    <= cmd_i.valid_count;
      status_q <= cmd_i.status;
      len_q    <= cmd_i.payload_length;
      last_q   <= cmd_i.last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, len_q, cnt_q, b2_q, b1_q, b0_q};
  assign m_axis_tuser  = status_q;
  assign m_axis_tlast  = last_q;

endmodule
`default_nettype wire

// ----- src/pixel_xor_frame_decoder.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pixel_xor_frame_decoder
// Decodes XOR-keyed payload bytes carried in an RGB pixel stream.
// ----------------------------------------------------------------------------
// Takes one pixel per clock with no gaps of its own: every pixel, header or
// payload, is accepted at once, and a result reaches the master side by way of
// a request queue entry, then the output register. A
// two-entry request queue sits between the frame tracker and the output
// register, so the input keeps flowing while one result waits on a stalled
// master side; the input stalls only once both entries are taken. Header
// pixels give no result unless the image is too small, a header check fails
// or the payload is empty; pixels outside a frame give none. The config port
// is always ready and must only be written while no result is outstanding.
// ----------------------------------------------------------------------------
module pixel_xor_frame_decoder (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  // configuration
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire logic [1:0]    cfg_index_i,
  input  wire logic [30:0]   cfg_data_i,
  // pixel input
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  input  wire logic [23:0]   s_axis_tdata,  // red[7:0], green[15:8], blue[23:16]
  input  wire logic          s_axis_tuser,  // frame_start
  // decoded output
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  // byte_first[7:0], byte_second[15:8], byte_third[23:16],
  // valid_count[25:24], payload_length[57:26], zero[63:58]
  output logic [63:0]        m_axis_tdata,
  output logic [2:0]         m_axis_tuser,  // status[2:0]
  output logic               m_axis_tlast
);
  import pxd_pkg::*;

  logic [23:0] key_low_q;
  logic [23:0] key_mid_q;
  logic [30:0] pixel_count_q;

  logic        in_accept;
  logic        push;
  cmd_t        push_cmd;
  logic        q_ready;
  logic        q_valid;
  cmd_t        q_cmd;
  logic        q_pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q     <= '0;
      key_mid_q     <= '0;
      pixel_count_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_KEY_LOW:     key_low_q     <= cfg_data_i[23:0];
        REG_KEY_MID:     key_mid_q     <= cfg_data_i[23:0];
        REG_PIXEL_COUNT: pixel_count_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign s_axis_tready = q_ready;
  assign in_accept     = s_axis_tvalid && q_ready;

  pxd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (in_accept),
    .frame_start_i (s_axis_tuser),
    .red_i         (s_axis_tdata[7:0]),
    .green_i       (s_axis_tdata[15:8]),
    .blue_i        (s_axis_tdata[23:16]),
    .pixel_count_i (pixel_count_q),
    .cmd_o         (push_cmd),
    .push_o        (push)
  );

  pxd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .ready_o     (q_ready),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_cmd)
  );

  pxd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .key_low_i     (key_low_q),
    .key_mid_i     (key_mid_q),
    .cmd_valid_i   (q_valid),
    .cmd_i         (q_cmd),
    .cmd_pop_o     (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
`default_nettype wire
